// ----- design/qte_pkg.sv -----
// Shared types, constants and helper functions for the quaternion to Euler
// angle pipeline. No dependencies; every other design file imports it.
package qte_pkg;

  localparam int IN_W              = 16;
  localparam int CW                = 36;   // CORDIC x/y datapath width
  localparam int AW                = 35;   // CORDIC angle width, Q2.30 signed
  localparam int ISQ_STAGES        = 31;   // one result bit per stage
  localparam int ISQ_W             = 62;
  localparam int ROOT_W            = 31;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam logic [15:0] THR_RESET   = 16'd32735;
  localparam logic [15:0] TWO_PI_Q13  = 16'd51472;
  localparam logic [15:0] HALF_PI_Q13 = 16'd12868;
  localparam logic [15:0] SOUTH_PITCH = 16'd38604;  // 2*pi - pi/2

  localparam logic signed [AW-1:0] PI_Q30     = 35'sd3373259426;
  localparam logic [CW-1:0]        ONE_Q30    = 36'd1073741824;
  localparam logic [ISQ_W-1:0]     ONE_SQ_Q60 = 62'd1 << 60;

  typedef enum logic [1:0] {
    POLE_GENERAL = 2'd0,
    POLE_NORTH   = 2'd1,
    POLE_SOUTH   = 2'd2
  } pole_e;

  // Operands that travel alongside the square root stages
  typedef struct packed {
    logic signed [CW-1:0] yaw_y;
    logic signed [CW-1:0] yaw_x;
    logic signed [CW-1:0] roll_y;
    logic signed [CW-1:0] roll_x;
    logic signed [31:0]   s;
    pole_e                pole;
  } side_t;

  localparam int SIDE_W = $bits(side_t);

  // atan(2^-i) in Q2.30
  function automatic logic [29:0] atan_q30(input int i);
    logic [29:0] r;
    case (i)
      0:  r = 30'd843314857;
      1:  r = 30'd497837829;
      2:  r = 30'd263043837;
      3:  r = 30'd133525159;
      4:  r = 30'd67021687;
      5:  r = 30'd33543516;
      6:  r = 30'd16775851;
      7:  r = 30'd8388437;
      8:  r = 30'd4194283;
      9:  r = 30'd2097149;
      default: begin
        if (i < 31) r = 30'd1 << (30 - i);
        else        r = 30'd0;
      end
    endcase
    return r;
  endfunction

  // Q2.30 to Q3.13 with round half up, wrapped into [0, 2*pi]
  function automatic logic [15:0] wrap_q13(input logic signed [36:0] a);
    logic signed [37:0] r;
    logic signed [20:0] v;
    logic signed [20:0] tp;
    tp = 21'sd51472;
    r  = 38'(a) + 38'sd65536;
    v  = 21'(r >>> 17);
    if (v > tp) v = v - tp;
    if (v < 21'sd0) v = v + tp;
    if (v > tp) v = tp;
    if (v < 21'sd0) v = 21'sd0;
    return v[15:0];
  endfunction

endpackage

// ----- design/quaternion_to_euler_angles.sv -----
// Quaternion to Euler angles with pole check. Takes one quaternion per cycle
// while s_axis_tready is high; results leave in order after five front
// stages (products, threshold test, asin operand), 31 square-root stages,
// one pre-rotation plus CORDIC_STAGES rotation stages, one wrap stage and
// the output register. An output register and a skid register sit at the
// end, so one result may wait on m_axis_tready while the pipeline still
// moves; a second wait stalls the whole pipeline. The user must write
// pole_threshold through the cfg port while the block is idle; the block
// does not enforce it. Depends on qte_pkg, qte_front, qte_isqrt and qte_cordic.
module quaternion_to_euler_angles #(
  parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // qx, qy, qz, qw
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // yaw, pitch, roll
  output logic [1:0]  m_axis_tuser,   // pole_case
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);
  import qte_pkg::*;

  logic [15:0] thr_q;
  logic        en;

  logic               fr_valid;
  logic [ISQ_W-1:0]   fr_n;
  side_t              fr_side;

  logic               sq_valid;
  logic [ROOT_W-1:0]  sq_root;
  side_t              sq_side;

  logic               cy_valid;
  logic signed [AW-1:0] yaw_ang, pitch_ang, roll_ang;
  logic [1:0]         cy_pole;

  logic               w_valid_q;
  logic [15:0]        w_yaw_q, w_pitch_q, w_roll_q;
  pole_e              w_pole_q;
  logic [15:0]        yaw_d, pitch_d, roll_d;
  pole_e              pole_d;
  logic signed [36:0] yaw2;

  logic               out_valid_q, sk_valid_q;
  logic [49:0]        out_q, sk_q;
  logic [49:0]        w_pack;
  logic               pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // pipeline advances unless the skid register is occupied
  assign en            = !sk_valid_q;
  assign s_axis_tready = en;

  qte_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .qx_i    (signed'(s_axis_tdata[15:0])),
    .qy_i    (signed'(s_axis_tdata[31:16])),
    .qz_i    (signed'(s_axis_tdata[47:32])),
    .qw_i    (signed'(s_axis_tdata[63:48])),
    .thr_i   (thr_q),
    .valid_o (fr_valid),
    .n_o     (fr_n),
    .side_o  (fr_side)
  );

  qte_isqrt #(.SIDE_BITS(SIDE_W)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .n_i     (fr_n),
    .side_i  (fr_side),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES), .SIDE_BITS(2)) u_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .y_i     (sq_side.yaw_y),
    .x_i     (sq_side.yaw_x),
    .side_i  (sq_side.pole),
    .valid_o (cy_valid),
    .ang_o   (yaw_ang),
    .side_o  (cy_pole)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES), .SIDE_BITS(1)) u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .y_i     (CW'(sq_side.s)),
    .x_i     (signed'(CW'(sq_root))),
    .side_i  (1'b0),
    .valid_o (),
    .ang_o   (pitch_ang),
    .side_o  ()
  );

  qte_cordic #(.STAGES(CORDIC_STAGES), .SIDE_BITS(1)) u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .y_i     (sq_side.roll_y),
    .x_i     (sq_side.roll_x),
    .side_i  (1'b0),
    .valid_o (),
    .ang_o   (roll_ang),
    .side_o  ()
  );

  always_comb begin
    pole_d = pole_e'(cy_pole);
    yaw2   = 37'(yaw_ang) <<< 1;
    case (pole_d)
      POLE_NORTH: begin
        yaw_d   = wrap_q13(yaw2);
        pitch_d = HALF_PI_Q13;
        roll_d  = '0;
      end
      POLE_SOUTH: begin
        yaw_d   = wrap_q13(-yaw2);
        pitch_d = SOUTH_PITCH;
        roll_d  = '0;
      end
      default: begin
        yaw_d   = wrap_q13(37'(yaw_ang));
        pitch_d = wrap_q13(37'(pitch_ang));
        roll_d  = wrap_q13(37'(roll_ang));
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_valid_q <= 1'b0;
    end else if (en) begin
      w_valid_q <= cy_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w_yaw_q   <= yaw_d;
      w_pitch_q <= pitch_d;
      w_roll_q  <= roll_d;
      w_pole_q  <= pole_d;
    end
  end

  assign w_pack = {w_pole_q, w_roll_q, w_pitch_q, w_yaw_q};
  assign pop    = out_valid_q && m_axis_tready;

  // output register plus skid: park a result when the output is stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sk_valid_q  <= 1'b0;
    end else if (sk_valid_q) begin
      if (pop) begin
        sk_valid_q <= 1'b0;
      end
    end else if (w_valid_q) begin
      if (out_valid_q && !pop) begin
        sk_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sk_valid_q) begin
      if (pop) begin
        out_q <= sk_q;
      end
    end else if (w_valid_q) begin
      if (out_valid_q && !pop) begin
        sk_q <= w_pack;
      end else begin
        out_q <= w_pack;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q[47:0];
  assign m_axis_tuser  = out_q[49:48];

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_valid_q |-> out_valid_q)
    else $error("skid register holds data while output is empty");

  a_pole_roll_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != POLE_GENERAL) |-> m_axis_tdata[47:32] == 16'd0)
    else $error("roll not zero on a pole result");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15:0] <= TWO_PI_Q13 &&
                       m_axis_tdata[31:16] <= TWO_PI_Q13 &&
                       m_axis_tdata[47:32] <= TWO_PI_Q13))
    else $error("angle outside [0, 2*pi]");

endmodule

// ----- design/qte_front.sv -----
// Front end: component products, pole test against the threshold, asin
// operand saturation and the square root radicand. Five register stages.
// Depends on qte_pkg.
module qte_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [qte_pkg::IN_W-1:0] qx_i,
  input  logic signed [qte_pkg::IN_W-1:0] qy_i,
  input  logic signed [qte_pkg::IN_W-1:0] qz_i,
  input  logic signed [qte_pkg::IN_W-1:0] qw_i,
  input  logic [15:0]                   thr_i,
  output logic                          valid_o,
  output logic [qte_pkg::ISQ_W-1:0]     n_o,
  output qte_pkg::side_t                side_o
);
  import qte_pkg::*;

  // stage 1: products
  logic               v1_q;
  logic signed [31:0] xx_q, yy_q, zz_q, ww_q;
  logic signed [31:0] xw_q, yz_q, zw_q, xy_q, zy_q, wx_q, zx_q, yw_q;
  logic signed [15:0] x1_q, y1_q;

  // stage 2: sums
  logic               v2_q;
  logic [32:0]        unit_q;
  logic signed [32:0] test2_q;
  logic signed [CW-1:0] gyy_q, gyx_q, gry_q, grx_q;
  logic signed [33:0] s2_q;
  logic signed [15:0] x2_q, y2_q;

  // stage 3: threshold product, saturation
  logic               v3_q;
  logic [48:0]        lim_q;
  logic signed [32:0] test3_q;
  logic signed [31:0] ssat_q;
  logic [30:0]        sabs_q;
  logic signed [CW-1:0] gyy3_q, gyx3_q, gry3_q, grx3_q;
  logic signed [15:0] x3_q, y3_q;

  // stage 4: s squared, pole decision
  logic               v4_q;
  logic [ISQ_W-1:0]   ssq_q;
  side_t              side4_q;

  // stage 5: radicand
  logic               v5_q;
  logic [ISQ_W-1:0]   n5_q;
  side_t              side5_q;

  logic signed [31:0] s_sat_d;
  logic signed [49:0] t16;
  logic signed [49:0] lim_s;
  logic               north, south;
  side_t              side4_d;

  always_comb begin
    if (s2_q > 34'sd1073741824)       s_sat_d = 32'sd1073741824;
    else if (s2_q < -34'sd1073741824) s_sat_d = -32'sd1073741824;
    else                              s_sat_d = 32'(s2_q);
  end

  always_comb begin
    t16   = 50'(test3_q) <<< 16;
    lim_s = signed'({1'b0, lim_q});
    north = t16 > lim_s;
    south = t16 < -lim_s;
    side4_d.roll_y = gry3_q;
    side4_d.roll_x = grx3_q;
    side4_d.s      = ssat_q;
    if (north || south) begin
      side4_d.yaw_y = CW'(y3_q) <<< 15;
      side4_d.yaw_x = CW'(x3_q) <<< 15;
      side4_d.pole  = north ? POLE_NORTH : POLE_SOUTH;
    end else begin
      side4_d.yaw_y = gyy3_q;
      side4_d.yaw_x = gyx3_q;
      side4_d.pole  = POLE_GENERAL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xx_q <= qx_i * qx_i;
      yy_q <= qy_i * qy_i;
      zz_q <= qz_i * qz_i;
      ww_q <= qw_i * qw_i;
      xw_q <= qx_i * qw_i;
      yz_q <= qy_i * qz_i;
      zw_q <= qz_i * qw_i;
      xy_q <= qx_i * qy_i;
      zy_q <= qz_i * qy_i;
      wx_q <= qw_i * qx_i;
      zx_q <= qz_i * qx_i;
      yw_q <= qy_i * qw_i;
      x1_q <= qx_i;
      y1_q <= qy_i;

      unit_q  <= 33'(xx_q) + 33'(yy_q) + 33'(zz_q) + 33'(ww_q);
      test2_q <= 33'(xw_q) - 33'(yz_q);
      gyy_q   <= (CW'(zw_q) + CW'(xy_q)) <<< 1;
      gyx_q   <= signed'(ONE_Q30) - ((CW'(yy_q) + CW'(ww_q)) <<< 1);
      gry_q   <= (CW'(zx_q) + CW'(yw_q)) <<< 1;
      grx_q   <= signed'(ONE_Q30) - ((CW'(xx_q) + CW'(yy_q)) <<< 1);
      s2_q    <= (34'(zy_q) - 34'(wx_q)) <<< 1;
      x2_q    <= x1_q;
      y2_q    <= y1_q;

      lim_q   <= 49'(thr_i) * 49'(unit_q);
      test3_q <= test2_q;
      ssat_q  <= s_sat_d;
      sabs_q  <= s_sat_d[31] ? 31'(-s_sat_d) : 31'(s_sat_d);
      gyy3_q  <= gyy_q;
      gyx3_q  <= gyx_q;
      gry3_q  <= gry_q;
      grx3_q  <= grx_q;
      x3_q    <= x2_q;
      y3_q    <= y2_q;

      ssq_q   <= 62'(sabs_q) * 62'(sabs_q);
      side4_q <= side4_d;

      n5_q    <= ONE_SQ_Q60 - ssq_q;
      side5_q <= side4_q;
    end
  end

  assign valid_o = v5_q;
  assign n_o     = n5_q;
  assign side_o  = side5_q;

endmodule

// ----- design/qte_isqrt.sv -----
// Pipelined integer square root, one result bit per register stage, with a
// side payload that moves in step. Depends on qte_pkg.
module qte_isqrt #(
  parameter int SIDE_BITS = qte_pkg::SIDE_W
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [qte_pkg::ISQ_W-1:0]  n_i,
  input  logic [SIDE_BITS-1:0]       side_i,
  output logic                       valid_o,
  output logic [qte_pkg::ROOT_W-1:0] root_o,
  output logic [SIDE_BITS-1:0]       side_o
);
  import qte_pkg::*;

  logic               v_in    [ISQ_STAGES];
  logic [ISQ_W-1:0]   n_in    [ISQ_STAGES];
  logic [ISQ_W-1:0]   r_in    [ISQ_STAGES];
  logic [SIDE_BITS-1:0] sd_in [ISQ_STAGES];
  logic               v_q     [ISQ_STAGES];
  logic [ISQ_W-1:0]   n_q     [ISQ_STAGES];
  logic [ISQ_W-1:0]   r_q     [ISQ_STAGES];
  logic [SIDE_BITS-1:0] sd_q  [ISQ_STAGES];

  for (genvar k = 0; k < ISQ_STAGES; k++) begin : g_stage
    localparam logic [ISQ_W-1:0] BIT = ISQ_W'(1) << (2 * (ISQ_STAGES - 1 - k));
    logic [ISQ_W-1:0] trial;
    logic [ISQ_W-1:0] n_d, r_d;

    if (k == 0) begin : g_first
      assign v_in[k]  = valid_i;
      assign n_in[k]  = n_i;
      assign r_in[k]  = '0;
      assign sd_in[k] = side_i;
    end else begin : g_next
      assign v_in[k]  = v_q[k-1];
      assign n_in[k]  = n_q[k-1];
      assign r_in[k]  = r_q[k-1];
      assign sd_in[k] = sd_q[k-1];
    end

    always_comb begin
      trial = r_in[k] + BIT;
      if (n_in[k] >= trial) begin
        n_d = n_in[k] - trial;
        r_d = (r_in[k] >> 1) + BIT;
      end else begin
        n_d = n_in[k];
        r_d = r_in[k] >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k]  <= n_d;
        r_q[k]  <= r_d;
        sd_q[k] <= sd_in[k];
      end
    end
  end

  assign valid_o = v_q[ISQ_STAGES-1];
  assign root_o  = r_q[ISQ_STAGES-1][ROOT_W-1:0];
  assign side_o  = sd_q[ISQ_STAGES-1];

endmodule

// ----- design/qte_cordic.sv -----
// Pipelined vectoring CORDIC giving atan2(y, x) in Q2.30: a quadrant
// pre-rotation stage, then one micro-rotation per stage. Depends on qte_pkg.
module qte_cordic #(
  parameter int STAGES    = qte_pkg::CORDIC_STAGES_DEF,
  parameter int SIDE_BITS = 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic signed [qte_pkg::CW-1:0]  y_i,
  input  logic signed [qte_pkg::CW-1:0]  x_i,
  input  logic [SIDE_BITS-1:0]           side_i,
  output logic                           valid_o,
  output logic signed [qte_pkg::AW-1:0]  ang_o,
  output logic [SIDE_BITS-1:0]           side_o
);
  import qte_pkg::*;

  // pre-rotation stage
  logic                 vp_q;
  logic                 zp_q;
  logic signed [CW-1:0] xp_q, yp_q;
  logic signed [AW-1:0] ap_q;
  logic [SIDE_BITS-1:0] sp_q;

  logic                 v_q  [STAGES];
  logic                 z_q  [STAGES];
  logic signed [CW-1:0] x_q  [STAGES];
  logic signed [CW-1:0] y_q  [STAGES];
  logic signed [AW-1:0] a_q  [STAGES];
  logic [SIDE_BITS-1:0] s_q  [STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (en_i) begin
      vp_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zp_q <= (x_i == '0) && (y_i == '0);
      sp_q <= side_i;
      if (x_i < 0) begin
        xp_q <= -x_i;
        yp_q <= -y_i;
        ap_q <= (y_i >= 0) ? PI_Q30 : -PI_Q30;
      end else begin
        xp_q <= x_i;
        yp_q <= y_i;
        ap_q <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    localparam logic signed [AW-1:0] ATAN = AW'(atan_q30(i));
    logic                 v_in, z_in;
    logic signed [CW-1:0] x_in, y_in;
    logic signed [AW-1:0] a_in;
    logic [SIDE_BITS-1:0] s_in;

    if (i == 0) begin : g_first
      assign v_in = vp_q;
      assign z_in = zp_q;
      assign x_in = xp_q;
      assign y_in = yp_q;
      assign a_in = ap_q;
      assign s_in = sp_q;
    end else begin : g_next
      assign v_in = v_q[i-1];
      assign z_in = z_q[i-1];
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign a_in = a_q[i-1];
      assign s_in = s_q[i-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        z_q[i] <= z_in;
        s_q[i] <= s_in;
        if (y_in >= 0) begin
          x_q[i] <= x_in + (y_in >>> i);
          y_q[i] <= y_in - (x_in >>> i);
          a_q[i] <= a_in + ATAN;
        end else begin
          x_q[i] <= x_in - (y_in >>> i);
          y_q[i] <= y_in + (x_in >>> i);
          a_q[i] <= a_in - ATAN;
        end
      end
    end
  end

  assign valid_o = v_q[STAGES-1];
  assign ang_o   = z_q[STAGES-1] ? '0 : a_q[STAGES-1];
  assign side_o  = s_q[STAGES-1];

endmodule

// ----- verif/quaternion_to_euler_angles_tb.sv -----
// Self-checking bench for quaternion_to_euler_angles: streams quaternions in,
// predicts yaw/pitch/roll and pole case in bit-true fixed point, compares.
// Depends on qte_pkg and the quaternion_to_euler_angles design files.
`timescale 1ns / 100ps

module quaternion_to_euler_angles_tb;
  import qte_pkg::*;

  typedef struct packed {
    logic [15:0] yaw;
    logic [15:0] pitch;
    logic [15:0] roll;
    pole_e       pole;
  } angles_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  quaternion_to_euler_angles uut (.*);

  always #5 clk_i = ~clk_i;

  logic [63:0] quat_q[$];
  angles_t     angles_q[$];
  logic [15:0] threshold = THR_RESET;
  int          errors = 0;
  int          n_checked = 0;
  int          quiet_cycles = 0;
  bit          calm = 1'b0;      // disables random idling
  bit          hold_off = 1'b0;
  bit          in_fire = 1'b0;   // input transfer at the last rising edge
  int          pole_seen[3];

  localparam longint ATAN_TAB[32] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2, 1, 0};

  function automatic longint vec_atan2(longint y, longint x);
    longint ang, dx, dy;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      ang = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; ang += ATAN_TAB[i];
      end else begin
        x -= dx; y += dy; ang -= ATAN_TAB[i];
      end
    end
    return ang;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic logic [15:0] to_q13(longint a);
    longint v;
    v = (a + 65536) >>> 17;
    if (v > 51472) v -= 51472;
    if (v < 0) v += 51472;
    if (v > 51472) v = 51472;
    if (v < 0) v = 0;
    return v[15:0];
  endfunction

  function automatic angles_t euler_of(logic [63:0] q, logic [15:0] thr);
    longint x, y, z, w, unit, test, lim, t16, a, s, mag;
    angles_t r;
    x = longint'($signed(q[15:0]));
    y = longint'($signed(q[31:16]));
    z = longint'($signed(q[47:32]));
    w = longint'($signed(q[63:48]));
    unit = x*x + y*y + z*z + w*w;
    test = x*w - y*z;
    lim  = longint'(thr) * unit;
    t16  = test * 65536;
    if (t16 > lim || t16 < -lim) begin
      a = 2 * vec_atan2(y * 32768, x * 32768);
      if (t16 > lim) begin
        r.yaw = to_q13(a); r.pitch = HALF_PI_Q13; r.pole = POLE_NORTH;
      end else begin
        r.yaw = to_q13(-a); r.pitch = SOUTH_PITCH; r.pole = POLE_SOUTH;
      end
      r.roll = '0;
      return r;
    end
    r.yaw = to_q13(vec_atan2(2*(z*w + x*y), 64'sd1073741824 - 2*(y*y + w*w)));
    s = 2*(z*y - w*x);
    if (s > 64'sd1073741824) s = 64'sd1073741824;
    if (s < -64'sd1073741824) s = -64'sd1073741824;
    mag = (s < 0) ? -s : s;
    r.pitch = to_q13(vec_atan2(s, int_sqrt((64'd1 << 60) - mag*mag)));
    r.roll = to_q13(vec_atan2(2*(z*x + y*w), 64'sd1073741824 - 2*(x*x + y*y)));
    r.pole = POLE_GENERAL;
    return r;
  endfunction

  // Driver: at the falling edge, present the next pending quaternion, drive tready
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_fire) begin
        angles_q.push_back(euler_of(s_axis_tdata, threshold));
        void'(quat_q.pop_front());
      end
      if (s_axis_tvalid && !in_fire) begin
        // hold the pending transfer
      end else if (quat_q.size() > 0 && !hold_off && (calm || $urandom_range(99) >= 20))
      begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= quat_q[0];
      end else begin
        s_axis_tvalid <= 1'b0;
      end
      m_axis_tready <= calm || ($urandom_range(99) >= 20);
    end
  end

  // Monitor: compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    angles_t got, want;
    if (rst_ni) begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if ((s_axis_tvalid && s_axis_tready) || (cfg_valid_i && cfg_ready_o) ||
          (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
               pole_e'(m_axis_tuser)};
        if (angles_q.size() == 0) begin
          $display("%0t: unexpected result yaw=%0d pitch=%0d roll=%0d pole=%0d",
                   $time, got.yaw, got.pitch, got.roll, got.pole);
          errors++;
        end else begin
          want = angles_q.pop_front();
          n_checked++;
          pole_seen[want.pole]++;
          if (got !== want) begin
            $display("%0t: expected yaw=%0d pitch=%0d roll=%0d pole=%0d",
                     $time, want.yaw, want.pitch, want.roll, want.pole);
            $display("%0t: actual   yaw=%0d pitch=%0d roll=%0d pole=%0d",
                     $time, got.yaw, got.pitch, got.roll, got.pole);
            errors++;
          end
        end
      end
      if (quiet_cycles > 20000) begin
        $display("quaternion_to_euler_angles: mismatch");
        $finish;
      end
    end
  end

  function automatic logic [63:0] pack_quat(logic [15:0] x, logic [15:0] y,
                                            logic [15:0] z, logic [15:0] w);
    return {w, z, y, x};
  endfunction

  function automatic logic [15:0] rand_comp(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(65535) >> $urandom_range(14));
      default: return 16'($urandom_range(2) == 0 ? 16'h8000 :
                          ($urandom_range(1) ? 16'h7FFF : 16'h0000));
    endcase
  endfunction

  // Random quaternion; some built near the poles to hit both pole paths
  function automatic logic [63:0] rand_quat();
    int kind;
    logic [15:0] a, b, e;
    kind = $urandom_range(9);
    if (kind < 2) begin
      // x = w = a, y = -z = b gives test = a*a + b*b, near north pole
      a = 16'($urandom_range(23170));
      b = 16'($urandom_range(23170));
      e = 16'($urandom_range(200));
      if (kind == 0) return pack_quat(a, b, -b + e, a);
      return pack_quat(a, b, b + e, -a);
    end
    return pack_quat(rand_comp(kind % 3), rand_comp(kind % 3),
                     rand_comp(kind % 3), rand_comp(kind % 3));
  endfunction

  task automatic drain();
    while (quat_q.size() > 0 || angles_q.size() > 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [15:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    threshold = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    static logic [15:0] thr_set[5] = '{16'd0, 16'd32768, 16'd65535, 16'd16384, THR_RESET};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, zero, unit axes, exact poles, oversized pitch operand
    quat_q.push_back(pack_quat(0, 0, 0, 0));
    quat_q.push_back(pack_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000));
    quat_q.push_back(pack_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    quat_q.push_back(pack_quat(16'h7FFF, 0, 0, 0));
    quat_q.push_back(pack_quat(0, 16'h7FFF, 0, 0));
    quat_q.push_back(pack_quat(0, 0, 16'h7FFF, 0));
    quat_q.push_back(pack_quat(0, 0, 0, 16'h7FFF));
    quat_q.push_back(pack_quat(16'h8000, 0, 0, 0));
    quat_q.push_back(pack_quat(16'h5A82, 0, 0, 16'h5A82));
    quat_q.push_back(pack_quat(16'h5A82, 0, 0, 16'hA57E));
    quat_q.push_back(pack_quat(16'h4000, 16'h4000, 16'hC000, 16'h4000));
    quat_q.push_back(pack_quat(16'h4000, 16'hC000, 16'hC000, 16'hC000));
    quat_q.push_back(pack_quat(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF));
    quat_q.push_back(pack_quat(16'h8000, 0, 0, 16'h7FFF));
    quat_q.push_back(pack_quat(0, 16'h7FFF, 16'h7FFF, 0));
    quat_q.push_back(pack_quat(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001));
    quat_q.push_back(pack_quat(16'h0001, 0, 0, 0));
    quat_q.push_back(pack_quat(0, 16'h8000, 0, 16'h8000));
    drain();

    // random phases under several thresholds, one with no idling
    foreach (thr_set[k]) begin
      write_threshold(thr_set[k]);
      calm = (k == 3);
      for (int i = 0; i < 340; i++) quat_q.push_back(rand_quat());
      if (k == 1) begin
        // pause the sender until the pipeline is empty
        while (quat_q.size() > 200) @(posedge clk_i);
        hold_off = 1'b1;
        while (angles_q.size() > 0 || s_axis_tvalid) @(posedge clk_i);
        hold_off = 1'b0;
      end
      drain();
    end

    $display("checked %0d results: %0d general, %0d north, %0d south",
             n_checked, pole_seen[0], pole_seen[1], pole_seen[2]);
    $display("directed corners plus random phases under five threshold values");
    if (errors == 0) $display("quaternion_to_euler_angles: match");
    else $display("quaternion_to_euler_angles: mismatch");
    $finish;
  end

endmodule

// ----- quaternion_to_euler_angles.f -----
design/qte_pkg.sv
design/qte_front.sv
design/qte_isqrt.sv
design/qte_cordic.sv
design/quaternion_to_euler_angles.sv
verif/quaternion_to_euler_angles_tb.sv
